FILE: rtl/bilinear_null_aware_interpolator_defines.svh
// Assertion helpers shared by the interpolator RTL.
`ifndef BILINEAR_NULL_AWARE_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_NULL_AWARE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BNAI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BNAI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bnai_pkg.sv
package bnai_pkg;

  localparam int unsigned SampleBits  = 24;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned NullBits    = 24;
  localparam int unsigned FracInBits  = FracBits + 1;
  localparam int unsigned ProdBits    = SampleBits + FracBits + 2;
  localparam int unsigned AccBits     = ProdBits + 2;
  localparam int unsigned WSumBits    = FracBits + 3;
  localparam int unsigned CmpBits     = (SampleBits > NullBits) ? SampleBits : NullBits;
  localparam int unsigned QuoBits     = SampleBits;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = NullBits;

  localparam logic [FracInBits-1:0] FracOne = FracInBits'(1) << FracBits;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgHonorNull,
    CfgNullMarker
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_top_left;
    logic signed [SampleBits-1:0] sample_top_right;
    logic signed [SampleBits-1:0] sample_bottom_left;
    logic signed [SampleBits-1:0] sample_bottom_right;
    logic [FracInBits-1:0]        col_frac;
    logic [FracInBits-1:0]        row_frac;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] interpolated;
    logic                         is_null;
  } out_item_t;

  typedef struct packed {
    logic                honor_null;
    logic [NullBits-1:0] null_marker;
  } cfg_t;

  // Samples ordered top left, top right, bottom left, bottom right.
  typedef struct packed {
    logic [3:0][SampleBits-1:0] smp;
    logic [3:0]                 keep;
    logic [FracInBits-1:0]      c;
    logic [FracInBits-1:0]      cc;
    logic [FracInBits-1:0]      r;
    logic [FracInBits-1:0]      rc;
    logic                       honor_null;
  } frac_t;

  typedef struct packed {
    logic [3:0][SampleBits-1:0] smp;
    logic [3:0]                 keep;
    logic [3:0][FracInBits-1:0] wgt;
    logic                       honor_null;
  } wgt_t;

  typedef struct packed {
    logic [3:0][ProdBits-1:0] prod;
    logic [WSumBits-1:0]      wsum;
    logic                     honor_null;
  } prod_t;

  typedef struct packed {
    logic [AccBits-1:0]  acc;
    logic [WSumBits-1:0] wsum;
    logic                honor_null;
  } acc_t;

  typedef struct packed {
    logic [AccBits-1:0]  rem;
    logic [WSumBits-1:0] dvs;
    logic [QuoBits-1:0]  quo;
    logic                neg;
    logic                is_null;
  } div_t;

endpackage

FILE: rtl/bnai_front.sv
module bnai_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bnai_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bnai_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bnai_pkg::prod_t    out_data_o
);

  localparam int unsigned F  = bnai_pkg::FracBits;
  localparam int unsigned FI = bnai_pkg::FracInBits;
  localparam int unsigned PB = bnai_pkg::ProdBits;
  localparam int unsigned WB = bnai_pkg::WSumBits;
  localparam int unsigned CB = bnai_pkg::CmpBits;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  bnai_pkg::frac_t s1_d, s1_q;
  bnai_pkg::wgt_t  s2_d, s2_q;
  bnai_pkg::prod_t s3_d, s3_q;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Stage 1: clamp fractions, form complements, flag null neighbors.
  always_comb begin
    logic signed [CB-1:0] null_ext;
    logic signed [CB-1:0] smp_ext;
    null_ext     = $signed(cfg_i.null_marker);
    s1_d.smp[0]  = in_data_i.sample_top_left;
    s1_d.smp[1]  = in_data_i.sample_top_right;
    s1_d.smp[2]  = in_data_i.sample_bottom_left;
    s1_d.smp[3]  = in_data_i.sample_bottom_right;
    for (int i = 0; i < 4; i++) begin
      smp_ext      = $signed(s1_d.smp[i]);
      s1_d.keep[i] = !cfg_i.honor_null || (smp_ext != null_ext);
    end
    s1_d.c  = (in_data_i.col_frac > bnai_pkg::FracOne) ? bnai_pkg::FracOne : in_data_i.col_frac;
    s1_d.r  = (in_data_i.row_frac > bnai_pkg::FracOne) ? bnai_pkg::FracOne : in_data_i.row_frac;
    s1_d.cc = bnai_pkg::FracOne - s1_d.c;
    s1_d.rc = bnai_pkg::FracOne - s1_d.r;
    s1_d.honor_null = cfg_i.honor_null;
  end

  // Stage 2: four weights, truncated back to the fraction grid.
  always_comb begin
    logic [FI-1:0]  fc;
    logic [FI-1:0]  fr;
    logic [2*F+1:0] p;
    s2_d.smp        = s1_q.smp;
    s2_d.keep       = s1_q.keep;
    s2_d.honor_null = s1_q.honor_null;
    for (int i = 0; i < 4; i++) begin
      fc          = ((i & 1) != 0) ? s1_q.c : s1_q.cc;
      fr          = ((i & 2) != 0) ? s1_q.r : s1_q.rc;
      p           = fc * fr;
      s2_d.wgt[i] = p[2*F:F];
    end
  end

  // Stage 3: weighted samples and the weight of the kept neighbors.
  always_comb begin
    logic signed [PB-1:0] prod;
    logic [WB-1:0]        wsum;
    wsum = '0;
    for (int i = 0; i < 4; i++) begin
      prod         = $signed(s2_q.smp[i]) * $signed({1'b0, s2_q.wgt[i]});
      s3_d.prod[i] = s2_q.keep[i] ? prod : '0;
      wsum         = wsum + (s2_q.keep[i] ? WB'(s2_q.wgt[i]) : '0);
    end
    s3_d.wsum       = wsum;
    s3_d.honor_null = s2_q.honor_null;
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_q;

endmodule

FILE: rtl/bnai_sum.sv
module bnai_sum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bnai_pkg::prod_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bnai_pkg::div_t  out_data_o
);

  localparam int unsigned AB = bnai_pkg::AccBits;
  localparam int unsigned WB = bnai_pkg::WSumBits;

  logic s4_valid_q, s5_valid_q;
  logic s4_ready, s5_ready;

  bnai_pkg::acc_t s4_d, s4_q;
  bnai_pkg::div_t s5_d, s5_q;

  assign s5_ready   = !s5_valid_q || out_ready_i;
  assign s4_ready   = !s4_valid_q || s5_ready;
  assign in_ready_o = s4_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid_q <= in_valid_i;
      end
      if (s5_ready) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  always_comb begin
    s4_d.acc = AB'($signed(in_data_i.prod[0])) + AB'($signed(in_data_i.prod[1]))
             + AB'($signed(in_data_i.prod[2])) + AB'($signed(in_data_i.prod[3]));
    s4_d.wsum       = in_data_i.wsum;
    s4_d.honor_null = in_data_i.honor_null;
  end

  // Split into sign and magnitude; plain mode divides by one in Q format.
  always_comb begin
    logic wsum_zero;
    wsum_zero    = (s4_q.wsum == '0);
    s5_d.neg     = s4_q.acc[AB-1];
    s5_d.rem     = s5_d.neg ? (~s4_q.acc + AB'(1)) : s4_q.acc;
    s5_d.is_null = s4_q.honor_null && wsum_zero;
    if (!s4_q.honor_null) begin
      s5_d.dvs = WB'(bnai_pkg::FracOne);
    end else if (wsum_zero) begin
      s5_d.dvs = WB'(1);
    end else begin
      s5_d.dvs = s4_q.wsum;
    end
    s5_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && in_valid_i) begin
      s4_q <= s4_d;
    end
    if (s5_ready && s4_valid_q) begin
      s5_q <= s5_d;
    end
  end

  assign out_valid_o = s5_valid_q;
  assign out_data_o  = s5_q;

endmodule

FILE: rtl/bnai_div.sv
`include "bilinear_null_aware_interpolator_defines.svh"

module bnai_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bnai_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bnai_pkg::div_t out_data_o
);

  localparam int unsigned AB = bnai_pkg::AccBits;
  localparam int unsigned N  = bnai_pkg::QuoBits;

  // stg[0] is the input, stg[j+1] the register of stage j.
  bnai_pkg::div_t stg [N+1];
  logic [N:0]     vin;
  logic [N:0]     rdy;

  assign stg[0] = in_data_i;
  assign vin[0] = in_valid_i;
  assign rdy[N] = out_ready_i;

  // One restoring step per stage, quotient MSB first.
  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned K = N - 1 - j;

    bnai_pkg::div_t st_d, st_q;
    logic           vld_q;
    logic [AB-1:0]  trial;

    assign rdy[j] = !vld_q || rdy[j+1];

    always_comb begin
      st_d  = stg[j];
      trial = AB'(stg[j].dvs) << K;
      if (stg[j].rem >= trial) begin
        st_d.rem    = stg[j].rem - trial;
        st_d.quo[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (rdy[j]) begin
        vld_q <= vin[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && vin[j]) begin
        st_q <= st_d;
      end
    end

    assign stg[j+1] = st_q;
    assign vin[j+1] = vld_q;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vin[N];
  assign out_data_o  = stg[N];

  `BNAI_ASSERT_IMPL(a_dvs_nonzero, clk_i, rst_ni, in_valid_i, in_data_i.dvs != '0, "zero divisor entered divider")
  `BNAI_ASSERT_NEXT(a_first_stage_load, clk_i, rst_ni, in_valid_i && rdy[0], vin[1], "transfer into divider lost")
  `BNAI_ASSERT_IMPL(a_rem_below_dvs, clk_i, rst_ni, vin[N], stg[N].rem < AB'(stg[N].dvs), "final remainder not below divisor")

endmodule

FILE: rtl/bilinear_null_aware_interpolator.sv
// Channel   Direction  Signals                              Transfer when
// ---------------------------------------------------------------------------
// in        input      in_valid_i, in_stall_o, in_data_i    valid && !stall
// out       output     out_valid_o, out_stall_i, out_data_o valid && !stall
// cfg       input      cfg_valid_i, cfg_ready_o, cfg_index_i,
//                      cfg_data_i                           valid && ready
//
// Takes one item per clock while the output is not stalled.
// The divider retires one quotient bit per stage.
// Reset clears all valid flags and both config registers; cfg_ready_o is always high.
// A stall only holds stages that carry an item, so empty stages keep filling.
`include "bilinear_null_aware_interpolator_defines.svh"

module bilinear_null_aware_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bnai_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bnai_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bnai_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [bnai_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int unsigned S  = bnai_pkg::SampleBits;
  localparam int unsigned CB = bnai_pkg::CmpBits;
  localparam int unsigned QB = bnai_pkg::QuoBits;

  localparam logic signed [S:0]  QMax   = $signed({2'b00, {(S-1){1'b1}}});
  localparam logic signed [S:0]  QMin   = $signed({2'b11, {(S-1){1'b0}}});
  localparam logic [QB-1:0]      QuoLim = {1'b1, {(QB-1){1'b0}}};

  bnai_pkg::cfg_t cfg_q;

  logic            fr_valid, fr_ready;
  bnai_pkg::prod_t fr_data;
  logic            sm_valid, sm_ready;
  bnai_pkg::div_t  sm_data;
  logic            dv_valid, dv_ready;
  bnai_pkg::div_t  dv_data;
  logic            front_ready;

  bnai_pkg::out_item_t out_d, out_q;
  logic                out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.honor_null  <= 1'b0;
      cfg_q.null_marker <= '0;
    end else if (cfg_valid_i) begin
      unique case (bnai_pkg::cfg_reg_e'(cfg_index_i))
        bnai_pkg::CfgHonorNull:  cfg_q.honor_null  <= cfg_data_i[0];
        bnai_pkg::CfgNullMarker: cfg_q.null_marker <= cfg_data_i[bnai_pkg::NullBits-1:0];
      endcase
    end
  end

  bnai_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  bnai_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_data),
    .out_valid_o (sm_valid),
    .out_ready_i (sm_ready),
    .out_data_o  (sm_data)
  );

  bnai_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sm_valid),
    .in_ready_o  (sm_ready),
    .in_data_i   (sm_data),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_data_o  (dv_data)
  );

  assign in_stall_o = !front_ready;
  assign dv_ready   = !out_valid_q || !out_stall_i;

  // Restore the sign, clamp to the sample range, substitute the null marker.
  always_comb begin
    logic signed [S:0]    q_mag;
    logic signed [S:0]    q_sgn;
    logic signed [S:0]    q_clip;
    logic signed [CB-1:0] null_ext;
    q_mag    = $signed({1'b0, dv_data.quo});
    q_sgn    = dv_data.neg ? -q_mag : q_mag;
    null_ext = $signed(cfg_q.null_marker);
    if (q_sgn > QMax) begin
      q_clip = QMax;
    end else if (q_sgn < QMin) begin
      q_clip = QMin;
    end else begin
      q_clip = q_sgn;
    end
    out_d.interpolated = dv_data.is_null ? null_ext[S-1:0] : q_clip[S-1:0];
    out_d.is_null      = dv_data.is_null;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dv_ready) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready && dv_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BNAI_ASSERT_IMPL(a_empty_no_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `BNAI_ASSERT_IMPL(a_quo_in_range, clk_i, rst_ni, dv_valid && !dv_data.is_null, (dv_data.quo < QuoLim) || (dv_data.neg && dv_data.quo == QuoLim), "quotient beyond sample range")
  `BNAI_ASSERT_IMPL(a_null_zero_sum, clk_i, rst_ni, dv_valid && dv_data.is_null, dv_data.quo == '0 && !dv_data.neg, "null result with nonzero sum")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bnai_pkg::*;

  localparam int unsigned Latency    = SampleBits + 6;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  localparam logic [SampleBits-1:0] SmpMax = SampleBits'((1 << (SampleBits - 1)) - 1);
  localparam logic [SampleBits-1:0] SmpMin = SampleBits'(1 << (SampleBits - 1));
  localparam longint ResHi = (64'sd1 <<< (SampleBits - 1)) - 1;
  localparam longint ResLo = -ResHi - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  // Shadow of the block's registers, updated on each config transfer.
  logic                       cfg_honor;
  logic signed [NullBits-1:0] cfg_marker;

  out_item_t expected_pixels[$];
  int pixels_in;
  int pixels_out;
  int mismatch_cnt;
  int marker_settings;
  int idle_cycles;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_req;
  int hold_left;

  bilinear_null_aware_interpolator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t interpolate_pixel(in_item_t px);
    longint    smp[4];
    longint    wgt[4];
    longint    c, r, cc, rc, acc, wsum, res, nullv;
    out_item_t o;
    smp[0] = longint'($signed(px.sample_top_left));
    smp[1] = longint'($signed(px.sample_top_right));
    smp[2] = longint'($signed(px.sample_bottom_left));
    smp[3] = longint'($signed(px.sample_bottom_right));
    c = longint'(px.col_frac);
    r = longint'(px.row_frac);
    if (c > longint'(FracOne)) c = longint'(FracOne);
    if (r > longint'(FracOne)) r = longint'(FracOne);
    cc = longint'(FracOne) - c;
    rc = longint'(FracOne) - r;
    wgt[0] = (cc * rc) >> FracBits;
    wgt[1] = (c * rc) >> FracBits;
    wgt[2] = (cc * r) >> FracBits;
    wgt[3] = (c * r) >> FracBits;
    nullv = longint'(cfg_marker);
    acc = 0;
    wsum = 0;
    o.is_null = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!cfg_honor || smp[i] != nullv) begin
        acc += smp[i] * wgt[i];
        wsum += wgt[i];
      end
    end
    if (!cfg_honor) begin
      res = acc / longint'(FracOne);
    end else if (wsum > 0) begin
      res = acc / wsum;
    end else begin
      res = nullv;
      o.is_null = 1'b1;
    end
    if (res > ResHi) res = ResHi;
    if (res < ResLo) res = ResLo;
    o.interpolated = res[SampleBits-1:0];
    return o;
  endfunction

  function automatic logic [SampleBits-1:0] smp_of(int v);
    return SampleBits'(v);
  endfunction

  function automatic logic [FracInBits-1:0] frac_of(int v);
    return FracInBits'(v);
  endfunction

  function automatic in_item_t make_pixel(logic [SampleBits-1:0] tl, logic [SampleBits-1:0] tr,
                                          logic [SampleBits-1:0] bl, logic [SampleBits-1:0] br,
                                          logic [FracInBits-1:0] c, logic [FracInBits-1:0] r);
    in_item_t px;
    px.sample_top_left     = tl;
    px.sample_top_right    = tr;
    px.sample_bottom_left  = bl;
    px.sample_bottom_right = br;
    px.col_frac            = c;
    px.row_frac            = r;
    return px;
  endfunction

  function automatic logic [SampleBits-1:0] rand_sample(int null_pct);
    int sel;
    sel = $urandom_range(9, 0);
    if ($urandom_range(99, 0) < null_pct) return cfg_marker;
    case (sel)
      0: return SmpMax;
      1: return SmpMin;
      2: return SampleBits'($urandom_range(2, 0)) - SampleBits'(1);
      default: return SampleBits'($urandom());
    endcase
  endfunction

  function automatic logic [FracInBits-1:0] rand_frac();
    int sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0: return '0;
      1: return FracOne;
      2: return FracInBits'($urandom_range(2**FracInBits - 1, FracOne + 1));
      3: return FracInBits'($urandom());
      default: return FracInBits'($urandom_range(FracOne, 0));
    endcase
  endfunction

  function automatic in_item_t rand_pixel(int null_pct);
    return make_pixel(rand_sample(null_pct), rand_sample(null_pct), rand_sample(null_pct),
                      rand_sample(null_pct), rand_frac(), rand_frac());
  endfunction

  // Check each result against the oldest prediction, then record new inputs.
  always @(posedge clk_i) begin : chk
    out_item_t want;
    if (out_valid_o && !out_stall_i) begin
      pixels_out++;
      if (expected_pixels.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: interpolated %0d is_null %0b",
                   out_data_o.interpolated, out_data_o.is_null);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data_o.interpolated !== want.interpolated ||
            out_data_o.is_null !== want.is_null) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: interpolated exp %0d got %0d, is_null exp %0b got %0b",
                     pixels_out, want.interpolated, out_data_o.interpolated,
                     want.is_null, out_data_o.is_null);
        end
      end
    end
    if (in_valid_i && !in_stall_o) begin
      pixels_in++;
      expected_pixels.push_back(interpolate_pixel(in_data_i));
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout with %0d results pending", expected_pixels.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Sink: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < sink_stall_pct);
    end
  end

  task automatic send_item(in_item_t px);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgHonorNull:  cfg_honor = data[0];
      CfgNullMarker: begin
        cfg_marker = data[NullBits-1:0];
        marker_settings++;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(logic honor, logic [NullBits-1:0] marker);
    drain_pipe();
    write_cfg(CfgHonorNull, CfgDataBits'(honor));
    write_cfg(CfgNullMarker, marker);
  endtask

  // Plain bilinear on the reset register values.
  task automatic test_plain_corners();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(make_pixel(SmpMax, SmpMax, SmpMax, SmpMax, '0, '0));
    send_item(make_pixel(SmpMin, SmpMin, SmpMin, SmpMin, FracOne, FracOne));
    send_item(make_pixel(SmpMax, SmpMin, SmpMin, SmpMax,
                         frac_of(FracOne / 2), frac_of(FracOne / 2)));
    send_item(make_pixel(SmpMax, smp_of(17), smp_of(-4000), SmpMin, '1, '1));
    send_item(make_pixel(smp_of(100), smp_of(-200), smp_of(300), smp_of(-400),
                         frac_of(FracOne + 1), '0));
    send_item(make_pixel(smp_of(-7), smp_of(9), SmpMin, smp_of(5), '0, frac_of(100000)));
    send_item(make_pixel('0, smp_of(-1), smp_of(1), smp_of(-1),
                         frac_of(1), frac_of(FracOne - 1)));
    send_item(make_pixel(smp_of(-1), smp_of(-1), smp_of(-1), smp_of(-1),
                         frac_of(12345), frac_of(54321)));
    send_item(make_pixel('0, '0, '0, '0, frac_of(FracOne / 2), frac_of(FracOne / 2)));
    send_item(make_pixel(SmpMax, SmpMin, '0, smp_of(123456),
                         frac_of(FracOne - 1), frac_of(1)));
  endtask

  // No weight left, zero-weight survivors, clamped fractions, marker extremes.
  task automatic test_null_corners();
    set_mode(1'b1, SmpMin);
    send_item(make_pixel(SmpMin, SmpMin, SmpMin, SmpMin, frac_of(777), frac_of(888)));
    send_item(make_pixel(SmpMax, SmpMin, SmpMin, SmpMin, FracOne, '0));
    send_item(make_pixel(SmpMax, SmpMin, SmpMin, SmpMin, '0, '0));
    send_item(make_pixel(SmpMin, SmpMin, SmpMin, smp_of(-12345),
                         frac_of(FracOne / 2), frac_of(FracOne / 2)));
    send_item(make_pixel(SmpMin, smp_of(4000), SmpMin, smp_of(-9000),
                         frac_of(21845), frac_of(21845)));
    send_item(make_pixel(SmpMax, smp_of(SmpMin + 1), smp_of(-1), SmpMax,
                         frac_of(40000), frac_of(20000)));
    send_item(make_pixel(smp_of(55), SmpMin, smp_of(66), smp_of(77), frac_of(70000), '0));
    set_mode(1'b1, SmpMax);
    send_item(make_pixel(SmpMax, SmpMax, SmpMax, SmpMax, FracOne, FracOne));
    send_item(make_pixel(SmpMin, SmpMax, smp_of(3), smp_of(SmpMax - 1),
                         frac_of(1), frac_of(1)));
    send_item(make_pixel(SmpMax, SmpMax, smp_of(-654321), SmpMax,
                         frac_of(100), frac_of(65000)));
    set_mode(1'b1, '0);
    send_item(make_pixel('0, smp_of(-5), smp_of(7), '0, frac_of(30000), frac_of(30000)));
    send_item(make_pixel('0, SmpMin, SmpMax, smp_of(-3), frac_of(1), frac_of(1)));
  endtask

  task automatic test_random_phase(logic honor, logic [NullBits-1:0] marker, int src_pct,
                                   int sink_pct, int null_pct, int count);
    set_mode(honor, marker);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int n = 0; n < count; n++) send_item(rand_pixel(null_pct));
    drain_pipe();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // Hold the sink off while the source keeps offering, so the input stalls.
  task automatic test_sink_holdoff();
    set_mode(1'b1, NullBits'($urandom()));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = HoldCycles;
    for (int n = 0; n < 150; n++) send_item(rand_pixel(30));
    drain_pipe();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgHonorNull;
    cfg_data_i      = '0;
    cfg_honor       = 1'b0;
    cfg_marker      = '0;
    pixels_in       = 0;
    pixels_out      = 0;
    mismatch_cnt    = 0;
    marker_settings = 0;
    idle_cycles     = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_req        = 0;
    hold_left       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_corners();
    test_null_corners();
    test_random_phase(1'b0, '0, 0, 0, 20, 250);
    test_random_phase(1'b1, '0, 45, 0, 35, 250);
    test_random_phase(1'b1, SmpMax, 0, 45, 35, 250);
    test_random_phase(1'b1, SmpMin, 31, 31, 35, 250);
    test_random_phase(1'b0, NullBits'($urandom()), 31, 31, 20, 250);
    test_random_phase(1'b1, NullBits'($urandom()), 0, 0, 35, 250);
    test_sink_holdoff();

    $display("Sent %0d pixels, checked %0d results, %0d mismatches, %0d marker values",
             pixels_in, pixels_out, mismatch_cnt, marker_settings);
    $display("Plain and null-aware modes under free flow, gaps, stalls and a long hold-off");
    if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bnai_pkg.sv
rtl/bnai_front.sv
rtl/bnai_sum.sv
rtl/bnai_div.sv
rtl/bilinear_null_aware_interpolator.sv
tb/sv/tb.sv
